[rtl/core/infix_to_postfix_converter_assert.svh]
// Assertion macros for the infix to postfix converter checkers.
// Depends on clk and rst_n being visible where the macros are used.
`ifndef INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH
`define INFIX_TO_POSTFIX_CONVERTER_ASSERT_SVH

// Same-cycle implication, disabled while in reset.
`define ITP_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("itp assertion failed");

// Next-cycle implication, disabled while in reset.
`define ITP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("itp assertion failed");

`endif

[rtl/core/itp_pkg.sv]
// Package for the infix to postfix converter: sizes, character codes,
// command types and character classification. No dependencies.
package itp_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);

    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_POW    = 8'h5E;
    localparam logic [7:0] CH_MUL    = 8'h2A;
    localparam logic [7:0] CH_DIV    = 8'h2F;
    localparam logic [7:0] CH_ADD    = 8'h2B;
    localparam logic [7:0] CH_SUB    = 8'h2D;
    localparam logic [7:0] CH_NUL    = 8'h00;

    // Command that drives every cell of the stack chain.
    typedef struct packed {
        logic       push;
        logic       pop;
        logic [7:0] data;
    } stack_cmd_t;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_PROC  = 3'b010,
        ST_FLUSH = 3'b100
    } ctrl_state_t;

    function automatic logic is_alnum(input logic [7:0] ch);
        return (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
               (ch >= 8'h30 && ch <= 8'h39);
    endfunction

    function automatic logic is_oper(input logic [7:0] ch);
        return ch == CH_ADD || ch == CH_SUB || ch == CH_MUL || ch == CH_DIV ||
               ch == CH_POW;
    endfunction

    function automatic logic [1:0] prec_of(input logic [7:0] ch);
        logic [1:0] p;
        p = 2'd0;
        if (ch == CH_ADD || ch == CH_SUB)
        begin
            p = 2'd1;
        end
        else if (ch == CH_MUL || ch == CH_DIV)
        begin
            p = 2'd2;
        end
        else if (ch == CH_POW)
        begin
            p = 2'd3;
        end
        return p;
    endfunction

endpackage

[rtl/core/infix_to_postfix_converter.sv]
// Top level of the shunting-yard infix to postfix converter.
// Depends on itp_pkg, itp_ctrl and itp_cell.
//
//  channel | direction | payload                         | marks
//  s_*     | in        | tdata[7:0] symbol               | tlast end_of_expr
//  m_*     | out       | tdata[7:0] out_symbol           | tlast last_of_expr,
//          |           |                                 | tuser overflow
//
// An item is accepted while idle; the sequencer then pops one operator per
// cycle while the output is not stalled, and ends with a closing step that
// pushes, discards the '(' or emits a letter or digit; the end flush pops each
// stacked entry and then emits the terminator. Letters and digits thus take
// only the accept and the closing step.
// Reset empties the stack; entries themselves are never cleared.
// A stalled output holds the sequencer, and the input waits meanwhile.
module infix_to_postfix_converter
    import itp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] symbol
    input  logic       s_tlast,   // end_of_expr
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_symbol
    output logic       m_tlast,   // last_of_expr
    output logic       m_tuser    // [0] overflow
);

    stack_cmd_t cmd;
    logic [7:0] cell_data [STACK_DEPTH];

    // Sequencer: accept a request, walk its pops, drive the output register.
    itp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .top      (cell_data[0]),
        .cmd      (cmd)
    );

    // Operator stack as a chain of cells; cell 0 is the top of stack.
    // Push shifts every entry one cell down, pop shifts one cell up.
    for (genvar i = 0; i < STACK_DEPTH; i++)
    begin : g_cell
        logic [7:0] above;
        logic [7:0] below;

        if (i == 0)
        begin : g_top
            assign above = cmd.data;
        end
        else
        begin : g_mid
            assign above = cell_data[i-1];
        end

        if (i == STACK_DEPTH - 1)
        begin : g_bottom
            assign below = cell_data[i];
        end
        else
        begin : g_inner
            assign below = cell_data[i+1];
        end

        itp_cell u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .from_above (above),
            .from_below (below),
            .data       (cell_data[i])
        );
    end

endmodule

[rtl/core/itp_cell.sv]
// One cell of the shift stack: holds one entry, takes its neighbor's on
// push or pop. Depends on itp_pkg.
module itp_cell
    import itp_pkg::*;
(
    input  logic       clk,
    input  stack_cmd_t cmd,
    input  logic [7:0] from_above,
    input  logic [7:0] from_below,
    output logic [7:0] data
);

    logic [7:0] data_reg;
    logic [7:0] data_next;

    always_comb
    begin
        data_next = data_reg;
        if (cmd.push)
        begin
            data_next = from_above;
        end
        else if (cmd.pop)
        begin
            data_next = from_below;
        end
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

endmodule

[rtl/core/itp_ctrl.sv]
// Sequencer of the converter: takes requests, steps pops one per cycle while
// the output is not stalled, holds the output register. Depends on itp_pkg.
module itp_ctrl
    import itp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,
    input  logic       s_tlast,
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,
    output logic       m_tlast,
    output logic       m_tuser,
    input  logic [7:0] top,
    output stack_cmd_t cmd
);

    ctrl_state_t      state_reg, state_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       sym_reg, sym_next;
    logic             last_reg, last_next;
    logic             drop_reg, drop_next;
    logic             mval_reg, mval_next;
    logic [7:0]       mdata_reg, mdata_next;
    logic             mlast_reg, mlast_next;
    logic             muser_reg, muser_next;

    logic can_emit;
    logic not_empty;
    logic is_full;
    logic emit;
    logic [7:0] emit_sym;
    logic emit_last;
    logic done;

    assign can_emit  = !mval_reg || m_tready;
    assign not_empty = count_reg != '0;
    assign is_full   = count_reg == CNT_W'(STACK_DEPTH);

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        sym_next   = sym_reg;
        last_next  = last_reg;
        drop_next  = drop_reg;
        mval_next  = mval_reg;
        mdata_next = mdata_reg;
        mlast_next = mlast_reg;
        muser_next = muser_reg;
        cmd        = '{push: 1'b0, pop: 1'b0, data: sym_reg};
        emit       = 1'b0;
        emit_sym   = CH_NUL;
        emit_last  = 1'b0;
        done       = 1'b0;

        if (mval_reg && m_tready)
        begin
            mval_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    sym_next  = s_tdata;
                    last_next = s_tlast;
                    // A push is dropped only when full and no pop frees a slot.
                    drop_next = is_full && ((s_tdata == CH_LPAREN) ||
                                (is_oper(s_tdata) && !(prec_of(top) >= prec_of(s_tdata))));
                    state_next = ST_PROC;
                end
            end
            ST_PROC:
            begin
                if (can_emit)
                begin
                    if (is_alnum(sym_reg))
                    begin
                        emit     = 1'b1;
                        emit_sym = sym_reg;
                        done     = 1'b1;
                    end
                    else if (sym_reg == CH_LPAREN)
                    begin
                        cmd.push = !is_full;
                        emit     = drop_reg && !last_reg;
                        done     = 1'b1;
                    end
                    else if (sym_reg == CH_RPAREN)
                    begin
                        if (not_empty && top != CH_LPAREN)
                        begin
                            cmd.pop  = 1'b1;
                            emit     = 1'b1;
                            emit_sym = top;
                        end
                        else
                        begin
                            // Discard the matching open paren, if any.
                            cmd.pop = not_empty;
                            done    = 1'b1;
                        end
                    end
                    else if (is_oper(sym_reg))
                    begin
                        if (not_empty && prec_of(top) >= prec_of(sym_reg))
                        begin
                            cmd.pop  = 1'b1;
                            emit     = 1'b1;
                            emit_sym = top;
                        end
                        else
                        begin
                            cmd.push = !is_full;
                            emit     = drop_reg && !last_reg;
                            done     = 1'b1;
                        end
                    end
                    else
                    begin
                        done = 1'b1;
                    end
                    if (done)
                    begin
                        state_next = last_reg ? ST_FLUSH : ST_IDLE;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (can_emit)
                begin
                    emit = 1'b1;
                    if (not_empty)
                    begin
                        cmd.pop  = 1'b1;
                        emit_sym = top;
                    end
                    else
                    begin
                        emit_last  = 1'b1;
                        state_next = ST_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cmd.push)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (cmd.pop)
        begin
            count_next = count_reg - CNT_W'(1);
        end

        if (emit)
        begin
            mval_next  = 1'b1;
            mdata_next = emit_sym;
            mlast_next = emit_last;
            muser_next = drop_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= '0;
            mval_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            mval_reg  <= mval_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sym_reg   <= sym_next;
        last_reg  <= last_next;
        drop_reg  <= drop_next;
        mdata_reg <= mdata_next;
        mlast_reg <= mlast_next;
        muser_reg <= muser_next;
    end

    assign s_tready = state_reg == ST_IDLE;
    assign m_tvalid = mval_reg;
    assign m_tdata  = mdata_reg;
    assign m_tlast  = mlast_reg;
    assign m_tuser  = muser_reg;

endmodule

[rtl/core/itp_checker.sv]
// Port-level checker for the converter, bound to the top level.
// Depends on infix_to_postfix_converter_assert.svh.
`include "infix_to_postfix_converter_assert.svh"

module itp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tvalid,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic       m_tlast,
    input logic       m_tuser
);

    // A stalled result holds its value.
    `ITP_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast) && $stable(m_tuser))
    // The terminator always carries a zero symbol.
    `ITP_ASSERT_SAME(a_term_zero, m_tvalid && m_tlast, m_tdata == 8'h00)
    // A zero symbol that is not the terminator only marks a dropped push.
    `ITP_ASSERT_SAME(a_zero_is_drop, m_tvalid && m_tdata == 8'h00 && !m_tlast, m_tuser)
    // One request at a time: no accept right after an accept.
    `ITP_ASSERT_NEXT(a_one_at_a_time, s_tvalid && s_tready, !s_tready)

endmodule

bind infix_to_postfix_converter itp_checker u_itp_checker (.*);
